### hdl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  localparam int unsigned CountBitsDefault = 16;
  localparam logic [15:0] CapReset = 16'd256;

  // byte slots of one job: 3 pending-surrogate, 4 code point, 3 replay, 1 literal
  localparam int unsigned JobSlots   = 11;
  localparam int unsigned SlotIdxW   = $clog2(JobSlots);
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic        finished;
    logic        success;
    logic [15:0] out_length;
  } out_item_t;

  typedef struct packed {
    logic [15:0] out_capacity;
  } cfg_item_t;

  // Work for the back part, one per accepted beat.
  typedef struct packed {
    logic [JobSlots-1:0][7:0] bytes;
    logic [JobSlots-1:0]      mask;
    logic                     fin;
    logic                     ok;
    logic                     clr;
  } job_t;

endpackage

`default_nettype wire

### hdl/jsu_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
`default_nettype none

interface jsu_chan_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/jsu_front.sv
// Parser front: classifies each source byte and builds a job of candidate bytes.
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] cap_i,
  jsu_chan_if.sink         in_i,
  output job_t             job_o,
  output logic             job_valid_o,
  input  wire logic        job_ready_i
);

  typedef enum logic [7:0] {
    MODE_WAIT        = 8'b0000_0001,
    MODE_TEXT        = 8'b0000_0010,
    MODE_ESC         = 8'b0000_0100,
    MODE_HEX1        = 8'b0000_1000,
    MODE_AFTER_HI    = 8'b0001_0000,
    MODE_AFTER_HI_BS = 8'b0010_0000,
    MODE_HEX2        = 8'b0100_0000,
    MODE_DONE        = 8'b1000_0000
  } mode_e;

  typedef struct packed {
    logic       lit_en;
    logic [7:0] lit;
    logic       fin;
    logic       ok;
    mode_e      mode;
  } tail_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [3:0]      m;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;

  localparam logic [20:0] CpReplace = 21'h00FFFD;
  localparam logic [20:0] CpPlane1  = 21'h010000;
  localparam logic [15:0] HiFirst   = 16'hD800;
  localparam logic [15:0] HiLast    = 16'hDBFF;
  localparam logic [15:0] LoFirst   = 16'hDC00;
  localparam logic [15:0] LoLast    = 16'hDFFF;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.b[0] = cp[7:0];
      e.m    = 4'b0001;
    end else if (cp <= 21'h7FF) begin
      e.b[0] = 8'hC0 | {3'b0, cp[10:6]};
      e.b[1] = 8'h80 | {2'b0, cp[5:0]};
      e.m    = 4'b0011;
    end else if (cp <= 21'hFFFF) begin
      e.b[0] = 8'hE0 | {4'b0, cp[15:12]};
      e.b[1] = 8'h80 | {2'b0, cp[11:6]};
      e.b[2] = 8'h80 | {2'b0, cp[5:0]};
      e.m    = 4'b0111;
    end else begin
      e.b[0] = 8'hF0 | {5'b0, cp[20:18]};
      e.b[1] = 8'h80 | {2'b0, cp[17:12]};
      e.b[2] = 8'h80 | {2'b0, cp[11:6]};
      e.b[3] = 8'h80 | {2'b0, cp[5:0]};
      e.m    = 4'b1111;
    end
    return e;
  endfunction

  function automatic hex_t hex_dec(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

  // plain string text
  function automatic tail_t text_tail(input logic [7:0] c);
    tail_t t;
    t      = '0;
    t.mode = MODE_TEXT;
    case (c)
      ChNul: begin
        t.fin  = 1'b1;
        t.mode = MODE_DONE;
      end
      ChQuote: begin
        t.fin  = 1'b1;
        t.ok   = 1'b1;
        t.mode = MODE_DONE;
      end
      ChBsl: t.mode = MODE_ESC;
      default: begin
        t.lit_en = 1'b1;
        t.lit    = c;
      end
    endcase
    return t;
  endfunction

  // byte right after a backslash
  function automatic tail_t esc_tail(input logic [7:0] c);
    tail_t t;
    t        = '0;
    t.mode   = MODE_TEXT;
    t.lit_en = 1'b1;
    t.lit    = c;
    case (c)
      ChNul: begin
        t.lit_en = 1'b0;
        t.fin    = 1'b1;
        t.mode   = MODE_DONE;
      end
      ChB: t.lit = 8'h08;
      ChF: t.lit = 8'h0C;
      ChN: t.lit = 8'h0A;
      ChR: t.lit = 8'h0D;
      ChT: t.lit = 8'h09;
      ChU: begin
        t.lit_en = 1'b0;
        t.mode   = MODE_HEX1;
      end
      default: t.lit = c;
    endcase
    return t;
  endfunction

  mode_e           mode_q, mode_d;
  logic [15:0]     hex_q, hex_d;
  logic [1:0]      seen_q, seen_d;
  logic [2:0][7:0] raw_q, raw_d;
  logic [15:0]     pend_q, pend_d;
  logic            ok_q, ok_d;

  logic        acc;
  logic [7:0]  b;
  hex_t        dig;
  logic [15:0] gath;
  tail_t       tl;
  logic        use_tail;
  logic        hi_en;
  logic        cp_en;
  logic        raw_en;
  logic [20:0] cp;
  utf8_t       enc_hi;
  utf8_t       enc_cp;

  assign in_i.ready  = job_ready_i;
  assign job_valid_o = in_i.valid;
  assign acc         = in_i.valid && job_ready_i;

  always_comb begin
    b        = in_i.data.in_byte;
    dig      = hex_dec(b);
    gath     = {hex_q[11:0], dig.val};
    mode_d   = mode_q;
    hex_d    = hex_q;
    seen_d   = seen_q;
    raw_d    = raw_q;
    pend_d   = pend_q;
    ok_d     = ok_q;
    tl       = '0;
    use_tail = 1'b0;
    hi_en    = 1'b0;
    cp_en    = 1'b0;
    raw_en   = 1'b0;
    cp       = '0;
    job_o    = '0;

    case (mode_q)
      MODE_WAIT: begin
        job_o.clr = 1'b1;
        if (b == ChQuote && cap_i != 16'd0) begin
          mode_d = MODE_TEXT;
        end else begin
          job_o.fin = 1'b1;
          ok_d      = 1'b0;
          mode_d    = MODE_DONE;
        end
      end
      MODE_TEXT: begin
        tl       = text_tail(b);
        use_tail = 1'b1;
      end
      MODE_ESC: begin
        tl       = esc_tail(b);
        use_tail = 1'b1;
      end
      MODE_HEX1: begin
        if (!dig.ok) begin
          cp_en    = 1'b1;
          cp       = CpReplace;
          raw_en   = 1'b1;
          tl       = text_tail(b);
          use_tail = 1'b1;
        end else begin
          if (seen_q != 2'd3) raw_d[seen_q] = b;
          hex_d  = gath;
          seen_d = seen_q + 2'd1;
          if (seen_q == 2'd3) begin
            if (gath >= HiFirst && gath <= HiLast) begin
              pend_d = gath;
              mode_d = MODE_AFTER_HI;
            end else begin
              cp_en  = 1'b1;
              cp     = {5'b0, gath};
              mode_d = MODE_TEXT;
            end
          end
        end
      end
      MODE_AFTER_HI: begin
        if (b == ChBsl) begin
          mode_d = MODE_AFTER_HI_BS;
        end else begin
          hi_en    = 1'b1;
          tl       = text_tail(b);
          use_tail = 1'b1;
        end
      end
      MODE_AFTER_HI_BS: begin
        if (b == ChU) begin
          mode_d = MODE_HEX2;
          hex_d  = '0;
          seen_d = '0;
        end else begin
          hi_en    = 1'b1;
          tl       = esc_tail(b);
          use_tail = 1'b1;
        end
      end
      MODE_HEX2: begin
        if (!dig.ok) begin
          hi_en    = 1'b1;
          cp_en    = 1'b1;
          cp       = CpReplace;
          raw_en   = 1'b1;
          tl       = text_tail(b);
          use_tail = 1'b1;
        end else begin
          if (seen_q != 2'd3) raw_d[seen_q] = b;
          hex_d  = gath;
          seen_d = seen_q + 2'd1;
          if (seen_q == 2'd3) begin
            if (gath >= LoFirst && gath <= LoLast) begin
              // surrogate pair joins into one plane 1..16 code point
              cp_en  = 1'b1;
              cp     = CpPlane1 + {1'b0, pend_q[9:0], gath[9:0]};
              mode_d = MODE_TEXT;
            end else begin
              hi_en = 1'b1;
              if (gath >= HiFirst && gath <= HiLast) begin
                pend_d = gath;
                mode_d = MODE_AFTER_HI;
              end else begin
                cp_en  = 1'b1;
                cp     = {5'b0, gath};
                mode_d = MODE_TEXT;
              end
            end
          end
        end
      end
      MODE_DONE: begin
        job_o.fin = 1'b1;
        job_o.ok  = ok_q;
      end
      default: begin
        mode_d = MODE_WAIT;
      end
    endcase

    if (use_tail) begin
      mode_d         = tl.mode;
      job_o.fin      = tl.fin;
      job_o.ok       = tl.ok;
      job_o.bytes[10] = tl.lit;
      job_o.mask[10]  = tl.lit_en;
      if (tl.fin) ok_d = tl.ok;
      if (tl.mode == MODE_HEX1) begin
        hex_d  = '0;
        seen_d = '0;
      end
    end

    enc_hi = utf8_enc({5'b0, pend_q});
    enc_cp = utf8_enc(cp);
    if (hi_en) begin
      job_o.bytes[2:0] = enc_hi.b[2:0];
      job_o.mask[2:0]  = enc_hi.m[2:0];
    end
    if (cp_en) begin
      job_o.bytes[6:3] = enc_cp.b;
      job_o.mask[6:3]  = enc_cp.m;
    end
    if (raw_en) begin
      job_o.bytes[9:7] = raw_q;
      job_o.mask[7]    = seen_q >= 2'd1;
      job_o.mask[8]    = seen_q >= 2'd2;
      job_o.mask[9]    = seen_q == 2'd3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_WAIT;
      hex_q  <= '0;
      seen_q <= '0;
      pend_q <= '0;
      ok_q   <= 1'b0;
    end else if (acc) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      seen_q <= seen_d;
      pend_q <= pend_d;
      ok_q   <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) raw_q <= raw_d;
  end

endmodule

`default_nettype wire

### hdl/jsu_queue.sv
// Short job queue between parser front and emitter back.
`default_nettype none

module jsu_queue import jsu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t push_data_i,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  output job_t      pop_data_o,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            ent_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = ent_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop)  rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    if (push && !pop) cnt_d = cnt_q + CntW'(1);
    if (pop && !push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue count out of range");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count missed a push");

  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("queue count missed a pop");
`endif

endmodule

`default_nettype wire

### hdl/jsu_back.sv
// Emitter back: walks a job's bytes, applies the capacity limit, drives results.
`default_nettype none

module jsu_back import jsu_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] cap_i,
  input  wire job_t        job_i,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  jsu_chan_if.source       out_o
);

  localparam int unsigned CmpW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

  logic                     act_q, act_d;
  logic [JobSlots-1:0][7:0] bytes_q, bytes_d;
  logic [JobSlots-1:0]      rem_q, rem_d;
  logic                     fin_q, fin_d;
  logic                     ok_q, ok_d;
  logic                     any_q, any_d;
  logic [COUNT_BITS-1:0]    count_q, count_d;
  logic                     outv_q, outv_d;
  out_item_t                out_q, out_d;

  logic                adv;
  logic                keep_ok;
  logic                keep_ok_nx;
  logic [JobSlots-1:0] eff;
  logic [JobSlots-1:0] rem_clr;
  logic [SlotIdxW-1:0] idx;
  logic                emit;
  logic                done;
  logic                take;
  out_item_t           res;

  assign adv = !outv_q || out_o.ready;

  // keep while count+1 < capacity and the counter has room
  assign keep_ok = (count_q != {COUNT_BITS{1'b1}}) &&
                   (CmpW'(count_q) + CmpW'(1) < CmpW'(cap_i));
  assign keep_ok_nx = (COUNT_BITS'(count_q + COUNT_BITS'(1)) != {COUNT_BITS{1'b1}}) &&
                      (CmpW'(count_q) + CmpW'(2) < CmpW'(cap_i));

  assign eff = keep_ok ? rem_q : '0;

  always_comb begin
    idx = '0;
    for (int i = JobSlots - 1; i >= 0; i--) begin
      if (eff[i]) idx = SlotIdxW'(i);
    end
  end

  always_comb begin
    rem_clr      = rem_q;
    rem_clr[idx] = 1'b0;
  end

  always_comb begin
    act_d   = act_q;
    bytes_d = bytes_q;
    rem_d   = rem_q;
    fin_d   = fin_q;
    ok_d    = ok_q;
    any_d   = any_q;
    count_d = count_q;
    emit    = 1'b0;
    done    = 1'b0;
    res     = '0;

    if (act_q && adv) begin
      if (eff != '0) begin
        emit           = 1'b1;
        res.out_byte   = bytes_q[idx];
        res.byte_valid = 1'b1;
        count_d        = count_q + COUNT_BITS'(1);
        rem_d          = rem_clr;
        any_d          = 1'b1;
        // later bytes are dropped once the buffer is full
        done           = !fin_q && (rem_clr == '0 || !keep_ok_nx);
        res.last       = done;
      end else if (fin_q) begin
        emit           = 1'b1;
        res.finished   = 1'b1;
        res.success    = ok_q;
        res.out_length = 16'(count_q);
        res.last       = 1'b1;
        done           = 1'b1;
      end else begin
        done     = 1'b1;
        emit     = !any_q;
        res.last = 1'b1;
      end
    end

    take = job_valid_i && (!act_q || done);
    if (take) begin
      act_d   = 1'b1;
      bytes_d = job_i.bytes;
      rem_d   = job_i.mask;
      fin_d   = job_i.fin;
      ok_d    = job_i.ok;
      any_d   = 1'b0;
      if (job_i.clr) count_d = '0;
    end else if (done) begin
      act_d = 1'b0;
    end

    outv_d = adv ? emit : outv_q;
    out_d  = (adv && emit) ? res : out_q;
  end

  assign job_ready_o = !act_q || done;
  assign out_o.valid = outv_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      rem_q   <= '0;
      fin_q   <= 1'b0;
      ok_q    <= 1'b0;
      any_q   <= 1'b0;
      count_q <= '0;
      outv_q  <= 1'b0;
    end else begin
      act_q   <= act_d;
      rem_q   <= rem_d;
      fin_q   <= fin_d;
      ok_q    <= ok_d;
      any_q   <= any_d;
      count_q <= count_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    out_q   <= out_d;
  end

`ifndef SYNTHESIS
  a_fin_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q |-> !(out_q.byte_valid && out_q.finished))
    else $error("finish beat carries a byte");

  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q && out_q.finished |-> out_q.last)
    else $error("finish beat not marked last");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      count_q == '0 || count_q == $past(count_q) + COUNT_BITS'(1))
    else $error("kept count jumped");
`endif

endmodule

`default_nettype wire

### hdl/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper: capacity register, front, queue, back.
//
// Usage:
//   in_i   : one source byte per beat, starting with the opening quote.
//   out_o  : result beats (decoded byte or end report); last marks the final
//            beat caused by one source byte, finished/success/out_length
//            report the end of the string.
//   cfg_i  : writes out_capacity; always ready, write only while idle.
// Jobs pass the queue and the back's job registers, then the output register.
// Throughput: while the receiver is ready, a byte that yields at most one result
//   goes through at one per cycle; a byte yielding N results holds the back end
//   until all N are out (one result beat per cycle from the back's output
//   register); N is up to 10 for a bad hex digit after a pending high surrogate.
// A two-entry job queue separates parsing from emitting; when the receiver
//   stalls, the queue fills and in_i.ready drops only once it is full.
// Reset: waits for the opening quote, kept count 0, out_capacity 256.
//   No clearing pass; the block is ready right after reset.
`default_nettype none

module json_string_unescape_utf8_top import jsu_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jsu_chan_if.sink   in_i,
  jsu_chan_if.sink   cfg_i,
  jsu_chan_if.source out_o
);

  logic [15:0] cap_q;

  job_t front_job;
  logic front_valid;
  logic front_ready;
  job_t back_job;
  logic back_valid;
  logic back_ready;

  // capacity register, single write beat
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.data.out_capacity;
    end
  end

  // front: state machine over source bytes, one job per beat
  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .in_i        (in_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  jsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // back: one result beat per cycle while the receiver is ready, owns the kept count
  jsu_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
